// ----- design/json_token_lexer_top_macros.svh -----
// Assertion macros shared by the lexer modules.
`ifndef JSON_TOKEN_LEXER_TOP_MACROS_SVH
`define JSON_TOKEN_LEXER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define JTL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_token_lexer: assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define JTL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_token_lexer: assertion failed");

`endif

// ----- design/jtl_pkg.sv -----
// Package with the types, codes and sizes shared by the JSON token lexer modules.
package jtl_pkg;

    localparam int POS_BITS     = 24;
    localparam int FIELD_BITS   = 24;
    localparam int WIDE_BITS    = (POS_BITS + 1 > FIELD_BITS + 1) ? POS_BITS + 1 : FIELD_BITS + 1;
    localparam int MAX_RESULTS  = 3;
    localparam int RES_CNT_BITS = 2;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_BITS   = 2;
    localparam int Q_CNT_BITS   = 3;

    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [WIDE_BITS-1:0] wide_t;

    localparam pos_t  POS_MAX = {POS_BITS{1'b1}};
    localparam wide_t LEN_CAP = wide_t'({FIELD_BITS{1'b1}});

    localparam logic [3:0] K_LBRACE = 4'd0;
    localparam logic [3:0] K_RBRACE = 4'd1;
    localparam logic [3:0] K_LBRACK = 4'd2;
    localparam logic [3:0] K_RBRACK = 4'd3;
    localparam logic [3:0] K_COLON  = 4'd4;
    localparam logic [3:0] K_COMMA  = 4'd5;
    localparam logic [3:0] K_NUMBER = 4'd6;
    localparam logic [3:0] K_STRING = 4'd7;
    localparam logic [3:0] K_SYMBOL = 4'd8;
    localparam logic [3:0] K_LONE   = 4'd9;
    localparam logic [3:0] K_END    = 4'd10;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [2:0] ESC_FRESH   = 3'd5;
    localparam logic [2:0] ESC_UNICODE = 3'd4;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'd0,
        MODE_PLUS   = 4'd1,
        MODE_MINUS  = 4'd2,
        MODE_DOT    = 4'd3,
        MODE_SLASH  = 4'd4,
        MODE_NUMBER = 4'd5,
        MODE_SYMBOL = 4'd6,
        MODE_STRING = 4'd7,
        MODE_LINE   = 4'd8,
        MODE_BLOCK  = 4'd9
    } mode_t;

    typedef struct packed {
        logic [3:0]            kind;
        logic [7:0]            lone_char;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  overflow;
        logic                  last;
    } result_t;

endpackage

// ----- design/json_token_lexer_top.sv -----
// Top level of the JSON token lexer: input register, lexer core and token queue.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   text_byte, end_of_text
//   output   out        out_valid / out_stall token_kind, lone_char, token_start,
//                                             token_length, position_overflow, last_of_run
//
// A byte beat is taken every cycle while out_stall is low and each byte yields at most one
// token; a byte that yields two or three tokens holds back the next byte while the
// single-token output port drains the four-entry token queue.
// A token passes through the input register and then the token queue before it is offered.
// Reset clears the lexer state and the queue at once; no clearing pass is needed.
// in_stall rises when the input register holds a byte and the queue cannot take three
// tokens; out_stall holds the queue head in place.
module json_token_lexer_top
    import jtl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            text_byte,
    input  logic                  end_of_text,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            token_kind,
    output logic [7:0]            lone_char,
    output logic [FIELD_BITS-1:0] token_start,
    output logic [FIELD_BITS-1:0] token_length,
    output logic                  position_overflow,
    output logic                  last_of_run
);

    logic                      hold_valid_reg, hold_valid_next;
    logic [7:0]                hold_byte_reg;
    logic                      hold_last_reg;
    logic                      accept, process, pop, room, not_empty;
    result_t [MAX_RESULTS-1:0] core_res;
    logic [RES_CNT_BITS-1:0]   core_count;
    result_t                   head;

    assign process  = hold_valid_reg && room;
    assign in_stall = hold_valid_reg && !room;
    assign accept   = in_valid && !in_stall;
    assign pop      = not_empty && !out_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (process)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= text_byte;
            hold_last_reg <= end_of_text;
        end
    end

    jtl_lex_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (process),
        .step_byte (hold_byte_reg),
        .step_last (hold_last_reg),
        .res       (core_res),
        .res_count (core_count)
    );

    jtl_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (core_count),
        .push_data  (core_res),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .room       (room)
    );

    assign out_valid         = not_empty;
    assign token_kind        = head.kind;
    assign lone_char         = head.lone_char;
    assign token_start       = head.start;
    assign token_length      = head.length;
    assign position_overflow = head.overflow;
    assign last_of_run       = head.last;

endmodule

// ----- design/jtl_lex_core.sv -----
// Lexer state registers and the single-pass step logic that turns one byte into tokens.
`include "json_token_lexer_top_macros.svh"

module jtl_lex_core
    import jtl_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step_en,
    input  logic [7:0]                        step_byte,
    input  logic                              step_last,
    output result_t [MAX_RESULTS-1:0]         res,
    output logic [RES_CNT_BITS-1:0]           res_count
);

    mode_t      mode_reg, mode_next, mode_mid;
    pos_t       byte_position_reg, byte_position_next;
    pos_t       pending_start_reg, pending_start_next, ps_mid;
    logic       quote_is_single_reg, quote_is_single_next, qs_mid;
    logic [2:0] esc_reg, esc_next, esc_mid;
    logic       saw_star_reg, saw_star_next, star_mid;
    logic       overflow_seen_reg, overflow_seen_next;

    logic       at_max, ovf_now;
    wide_t      p_w, after_w, ps_w, ps_mid_w;
    logic       b_digit, b_white, b_numc, b_break, b_struct;
    logic [3:0] struct_kind;
    logic       do_begin, begin_valid;
    logic       close_valid;
    logic [3:0] close_kind;
    logic [7:0] close_char;
    wide_t      close_start, close_end;
    logic [7:0] qch;

    function automatic logic [7:0] pend_char(mode_t m);
        logic [7:0] c;
        case (m)
            MODE_PLUS:  c = CH_PLUS;
            MODE_MINUS: c = CH_MINUS;
            MODE_DOT:   c = CH_DOT;
            default:    c = CH_SLASH;
        endcase
        return c;
    endfunction

    function automatic result_t make_result(logic [3:0] kind, logic [7:0] ch, wide_t s_w,
                                            wide_t e_w, logic ovf);
        result_t r;
        wide_t   len;
        len = (e_w >= s_w) ? e_w - s_w : '0;
        if (len > LEN_CAP)
        begin
            len = LEN_CAP;
        end
        r.kind      = kind;
        r.lone_char = ch;
        r.start     = FIELD_BITS'(s_w);
        r.length    = FIELD_BITS'(len);
        r.overflow  = ovf;
        r.last      = 1'b0;
        return r;
    endfunction

    assign at_max   = (byte_position_reg == POS_MAX);
    assign ovf_now  = overflow_seen_reg | at_max;
    assign p_w      = wide_t'(byte_position_reg);
    assign after_w  = at_max ? p_w : p_w + wide_t'(1);
    assign ps_w     = wide_t'(pending_start_reg);
    assign ps_mid_w = wide_t'(ps_mid);

    assign b_digit = (step_byte >= CH_ZERO) && (step_byte <= CH_NINE);
    assign b_white = (step_byte == CH_TAB) || (step_byte == CH_LF) || (step_byte == CH_VT)
                  || (step_byte == CH_FF) || (step_byte == CH_CR) || (step_byte == CH_SPACE);
    assign b_numc  = b_digit || (step_byte == CH_LOWER_E) || (step_byte == CH_UPPER_E)
                  || (step_byte == CH_PLUS) || (step_byte == CH_MINUS) || (step_byte == CH_DOT);

    always_comb
    begin
        b_struct    = 1'b1;
        struct_kind = K_LBRACE;
        case (step_byte)
            CH_LBRACE: struct_kind = K_LBRACE;
            CH_RBRACE: struct_kind = K_RBRACE;
            CH_LBRACK: struct_kind = K_LBRACK;
            CH_RBRACK: struct_kind = K_RBRACK;
            CH_COLON:  struct_kind = K_COLON;
            CH_COMMA:  struct_kind = K_COMMA;
            default:   b_struct    = 1'b0;
        endcase
    end

    assign b_break = b_struct || b_white || (step_byte == CH_PLUS) || (step_byte == CH_MINUS)
                  || (step_byte == CH_DOT) || (step_byte == CH_DQUOTE);
    assign qch     = quote_is_single_reg ? CH_SQUOTE : CH_DQUOTE;

    // Main step: the token that this byte closes, then the token that it starts.
    always_comb
    begin
        mode_mid    = mode_reg;
        ps_mid      = pending_start_reg;
        qs_mid      = quote_is_single_reg;
        esc_mid     = esc_reg;
        star_mid    = saw_star_reg;
        do_begin    = 1'b0;
        begin_valid = 1'b0;
        close_valid = 1'b0;
        close_kind  = K_LONE;
        close_char  = '0;
        close_start = ps_w;
        close_end   = ps_w + wide_t'(1);
        case (mode_reg)
            MODE_PLUS, MODE_MINUS, MODE_DOT:
            begin
                if (b_digit)
                begin
                    mode_mid = MODE_NUMBER;
                end
                else
                begin
                    close_valid = 1'b1;
                    close_char  = pend_char(mode_reg);
                    do_begin    = 1'b1;
                end
            end
            MODE_SLASH:
            begin
                if (step_byte == CH_SLASH)
                begin
                    mode_mid = MODE_LINE;
                end
                else if (step_byte == CH_STAR)
                begin
                    mode_mid = MODE_BLOCK;
                    star_mid = 1'b0;
                end
                else
                begin
                    close_valid = 1'b1;
                    close_char  = CH_SLASH;
                    do_begin    = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (!b_numc)
                begin
                    close_valid = 1'b1;
                    close_kind  = K_NUMBER;
                    close_end   = p_w;
                    do_begin    = 1'b1;
                end
            end
            MODE_SYMBOL:
            begin
                if (b_break)
                begin
                    close_valid = 1'b1;
                    close_kind  = K_SYMBOL;
                    close_end   = p_w;
                    do_begin    = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (esc_reg == ESC_FRESH)
                begin
                    esc_mid = (step_byte == CH_U) ? ESC_UNICODE : 3'd0;
                end
                else if (esc_reg != 3'd0)
                begin
                    esc_mid = esc_reg - 3'd1;
                end
                else if (step_byte == qch)
                begin
                    close_valid = 1'b1;
                    close_kind  = K_STRING;
                    close_end   = after_w;
                    mode_mid    = MODE_IDLE;
                end
                else if (step_byte == CH_BSLASH)
                begin
                    esc_mid = ESC_FRESH;
                end
            end
            MODE_LINE:
            begin
                if (step_byte == CH_LF)
                begin
                    mode_mid = MODE_IDLE;
                end
            end
            MODE_BLOCK:
            begin
                if (saw_star_reg && (step_byte == CH_SLASH))
                begin
                    mode_mid = MODE_IDLE;
                    star_mid = 1'b0;
                end
                else
                begin
                    star_mid = (step_byte == CH_STAR);
                end
            end
            default:
            begin
                do_begin = 1'b1;
            end
        endcase

        if (do_begin)
        begin
            ps_mid = byte_position_reg;
            if (b_white)
            begin
                mode_mid = MODE_IDLE;
            end
            else if (b_struct)
            begin
                begin_valid = 1'b1;
                mode_mid    = MODE_IDLE;
            end
            else if (step_byte == CH_SLASH)
            begin
                mode_mid = MODE_SLASH;
            end
            else if (step_byte == CH_PLUS)
            begin
                mode_mid = MODE_PLUS;
            end
            else if (step_byte == CH_MINUS)
            begin
                mode_mid = MODE_MINUS;
            end
            else if (step_byte == CH_DOT)
            begin
                mode_mid = MODE_DOT;
            end
            else if (b_digit)
            begin
                mode_mid = MODE_NUMBER;
            end
            else if ((step_byte == CH_DQUOTE) || (step_byte == CH_SQUOTE))
            begin
                mode_mid = MODE_STRING;
                qs_mid   = (step_byte == CH_SQUOTE);
                esc_mid  = 3'd0;
            end
            else
            begin
                mode_mid = MODE_SYMBOL;
            end
        end
    end

    // Next state; the final byte of a text returns everything to its reset value.
    always_comb
    begin
        mode_next            = mode_reg;
        byte_position_next   = byte_position_reg;
        pending_start_next   = pending_start_reg;
        quote_is_single_next = quote_is_single_reg;
        esc_next             = esc_reg;
        saw_star_next        = saw_star_reg;
        overflow_seen_next   = overflow_seen_reg;
        if (step_en)
        begin
            if (step_last)
            begin
                mode_next            = MODE_IDLE;
                byte_position_next   = '0;
                pending_start_next   = '0;
                quote_is_single_next = 1'b0;
                esc_next             = 3'd0;
                saw_star_next        = 1'b0;
                overflow_seen_next   = 1'b0;
            end
            else
            begin
                mode_next            = mode_mid;
                byte_position_next   = at_max ? byte_position_reg
                                              : byte_position_reg + pos_t'(1);
                pending_start_next   = ps_mid;
                quote_is_single_next = qs_mid;
                esc_next             = esc_mid;
                saw_star_next        = star_mid;
                overflow_seen_next   = ovf_now;
            end
        end
    end

    // Outputs: up to four candidate tokens, packed in order into at most three slots.
    always_comb
    begin
        result_t [3:0]         cand;
        logic [3:0]            cand_v;
        logic [RES_CNT_BITS:0] n;
        logic                  tail_lone;
        logic [3:0]            tail_kind;

        tail_lone = (mode_mid == MODE_PLUS) || (mode_mid == MODE_MINUS)
                 || (mode_mid == MODE_DOT) || (mode_mid == MODE_SLASH);
        case (mode_mid)
            MODE_NUMBER: tail_kind = K_NUMBER;
            MODE_SYMBOL: tail_kind = K_SYMBOL;
            MODE_STRING: tail_kind = K_STRING;
            default:     tail_kind = K_LONE;
        endcase

        cand[0]   = make_result(close_kind, close_char, close_start, close_end, ovf_now);
        cand_v[0] = close_valid;
        cand[1]   = make_result(struct_kind, 8'd0, p_w, p_w + wide_t'(1), ovf_now);
        cand_v[1] = begin_valid;
        if (tail_lone)
        begin
            cand[2] = make_result(K_LONE, pend_char(mode_mid), ps_mid_w,
                                  ps_mid_w + wide_t'(1), ovf_now);
        end
        else
        begin
            cand[2] = make_result(tail_kind, 8'd0, ps_mid_w, after_w, ovf_now);
        end
        cand_v[2] = step_last && (tail_lone || (mode_mid == MODE_NUMBER)
                 || (mode_mid == MODE_SYMBOL) || (mode_mid == MODE_STRING));
        cand[3]   = make_result(K_END, 8'd0, after_w, after_w, ovf_now);
        cand_v[3] = step_last;

        res = '0;
        n   = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && (n < (RES_CNT_BITS + 1)'(MAX_RESULTS)))
            begin
                res[n[RES_CNT_BITS-1:0]] = cand[i];
                n = n + (RES_CNT_BITS + 1)'(1);
            end
        end
        if (n != '0)
        begin
            res[RES_CNT_BITS'(n - (RES_CNT_BITS + 1)'(1))].last = 1'b1;
        end
        res_count = step_en ? RES_CNT_BITS'(n) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_IDLE;
            byte_position_reg   <= '0;
            pending_start_reg   <= '0;
            quote_is_single_reg <= 1'b0;
            esc_reg             <= 3'd0;
            saw_star_reg        <= 1'b0;
            overflow_seen_reg   <= 1'b0;
        end
        else
        begin
            mode_reg            <= mode_next;
            byte_position_reg   <= byte_position_next;
            pending_start_reg   <= pending_start_next;
            quote_is_single_reg <= quote_is_single_next;
            esc_reg             <= esc_next;
            saw_star_reg        <= saw_star_next;
            overflow_seen_reg   <= overflow_seen_next;
        end
    end

    `JTL_ASSERT_IMP(a_last_gives_token, step_en && step_last, res_count != '0)
    `JTL_ASSERT_NXT(a_last_resets, step_en && step_last,
                    (mode_reg == MODE_IDLE) && (byte_position_reg == '0))
    `JTL_ASSERT_IMP(a_overflow_at_max, overflow_seen_reg, byte_position_reg == POS_MAX)

endmodule

// ----- design/jtl_result_queue.sv -----
// Four-entry token queue that takes up to three tokens per cycle and hands out one.
`include "json_token_lexer_top_macros.svh"

module jtl_result_queue
    import jtl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [RES_CNT_BITS-1:0]   push_count,
    input  result_t [MAX_RESULTS-1:0] push_data,
    input  logic                      pop,
    output result_t                   head,
    output logic                      not_empty,
    output logic                      room
);

    result_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0]  count_reg, count_next;
    logic [Q_CNT_BITS-1:0]  count_after_pop;
    logic [Q_CNT_BITS:0]    fill_check;

    assign not_empty       = (count_reg != '0);
    assign head            = entry_reg[rd_ptr_reg];
    assign count_after_pop = count_reg - Q_CNT_BITS'(pop);
    assign room            = (count_after_pop <= Q_CNT_BITS'(Q_DEPTH - MAX_RESULTS));
    assign fill_check      = (Q_CNT_BITS + 1)'(count_after_pop) + (Q_CNT_BITS + 1)'(push_count);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + Q_PTR_BITS'(pop);
        count_next  = count_after_pop + Q_CNT_BITS'(push_count);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (RES_CNT_BITS'(i) < push_count)
            begin
                entry_reg[Q_PTR_BITS'(wr_ptr_reg + Q_PTR_BITS'(i))] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `JTL_ASSERT_IMP(a_no_overfill, push_count != '0,
                    fill_check <= (Q_CNT_BITS + 1)'(Q_DEPTH))
    `JTL_ASSERT_IMP(a_pop_needs_entry, pop, count_reg != '0)
    `JTL_ASSERT_NXT(a_pop_drains, pop && (push_count == '0),
                    count_reg == $past(count_reg) - Q_CNT_BITS'(1))

endmodule
